### sv/adc_ebd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package adc_ebd_pkg;

  localparam int ChannelsDefault = 16;
  localparam int QueueDepth      = 2;

  localparam int WordW  = 32;
  localparam int SlotW  = 5;
  localparam int CrateW = 8;
  localparam int MaxW   = 13;
  localparam int ChanW  = 4;
  localparam int ValueW = 12;
  localparam int CountW = 6;
  localparam int SeenW  = 7;
  localparam int EventW = 24;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  localparam logic [2:0] TYPE_DATA      = 3'h0;
  localparam logic [2:0] TYPE_HEADER    = 3'h2;
  localparam logic [2:0] TYPE_END       = 3'h4;
  localparam logic [2:0] TYPE_NOT_VALID = 3'h6;

  localparam logic [CfgIdxW-1:0] REG_SLOT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CRATE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX   = 2'd2;

  localparam logic [MaxW-1:0] MAX_VALUE_RESET = 13'h1000;

  typedef enum logic [2:0] {
    CLS_DATA      = 3'd0,
    CLS_CHAN_BAD  = 3'd1,
    CLS_HDR_OK    = 3'd2,
    CLS_HDR_BAD   = 3'd3,
    CLS_END       = 3'd4,
    CLS_NOT_VALID = 3'd5,
    CLS_OTHER     = 3'd6
  } word_cls_t;

  typedef enum logic [2:0] {
    K_DATA      = 3'd0,
    K_END       = 3'd1,
    K_NOT_VALID = 3'd2,
    K_MISMATCH  = 3'd3,
    K_CHAN_ERR  = 3'd4,
    K_STRAY     = 3'd5
  } kind_t;

  typedef struct packed {
    word_cls_t         cls;
    logic [ChanW-1:0]  channel;
    logic [ValueW-1:0] value;
    logic              stored;
    logic [CountW-1:0] hdr_count;
    logic [EventW-1:0] event_count;
  } cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [ChanW-1:0]  channel;
    logic [ValueW-1:0] value;
    logic              stored;
    logic              closed_by_count;
    logic [EventW-1:0] event_count;
  } result_t;

  localparam int CmdW    = $bits(cmd_t);
  localparam int ResultW = $bits(result_t);

endpackage
`default_nettype wire

### sv/adc_ebd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module adc_ebd_fifo import adc_ebd_pkg::*; #(
  parameter int Width = CmdW,
  parameter int Depth = QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [Width-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [Width-1:0]      rdata,
  output logic                  empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### sv/adc_ebd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module adc_ebd_front import adc_ebd_pkg::*; #(
  parameter int Channels = ChannelsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic [WordW-1:0]    word,
  output cmd_t                     cmd
);

  logic [SlotW-1:0]  slot_r;
  logic [CrateW-1:0] crate_r;
  logic [MaxW-1:0]   max_value_r;
  logic [2:0]        wtype;
  logic              hdr_match;
  logic              chan_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      crate_r     <= '0;
      max_value_r <= MAX_VALUE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOT:  slot_r      <= cfg_data[SlotW-1:0];
        REG_CRATE: crate_r     <= cfg_data[CrateW-1:0];
        REG_MAX:   max_value_r <= cfg_data[MaxW-1:0];
        default: ;
      endcase
    end
  end

  assign wtype     = word[26:24];
  assign hdr_match = (word[31:27] == slot_r) && (word[23:16] == crate_r);
  assign chan_ok   = ({1'b0, word[20:17]} < 5'(Channels));

  always_comb begin
    cmd.channel     = word[20:17];
    cmd.value       = word[11:0];
    cmd.stored      = (word[13:12] == 2'b00) && ({1'b0, word[11:0]} <= max_value_r);
    cmd.hdr_count   = word[13:8];
    cmd.event_count = word[23:0];
    unique case (wtype)
      TYPE_DATA:      cmd.cls = chan_ok ? CLS_DATA : CLS_CHAN_BAD;
      TYPE_HEADER:    cmd.cls = hdr_match ? CLS_HDR_OK : CLS_HDR_BAD;
      TYPE_END:       cmd.cls = CLS_END;
      TYPE_NOT_VALID: cmd.cls = CLS_NOT_VALID;
      default:        cmd.cls = CLS_OTHER;
    endcase
  end

endmodule
`default_nettype wire

### sv/adc_ebd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module adc_ebd_back import adc_ebd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  output result_t   res,
  output logic      res_push,
  input  wire logic res_full
);

  logic              in_block_r, in_block_nxt;
  logic [CountW-1:0] expected_r, expected_nxt;
  logic [SeenW-1:0]  seen_r, seen_nxt;
  logic [SeenW-1:0]  seen_inc;
  logic              fire;

  assign fire     = !cmd_empty && !res_full;
  assign cmd_pop  = fire;
  assign seen_inc = seen_r + 1'b1;

  always_comb begin
    in_block_nxt        = in_block_r;
    expected_nxt        = expected_r;
    seen_nxt            = seen_r;
    res_push            = 1'b0;
    res.kind            = K_STRAY;
    res.channel         = '0;
    res.value           = '0;
    res.stored          = 1'b0;
    res.closed_by_count = 1'b0;
    res.event_count     = '0;
    if (fire) begin
      if (!in_block_r) begin
        unique case (cmd.cls)
          CLS_HDR_OK: begin
            in_block_nxt = 1'b1;
            expected_nxt = cmd.hdr_count;
            seen_nxt     = '0;
          end
          CLS_HDR_BAD: begin
            res_push = 1'b1;
            res.kind = K_MISMATCH;
          end
          CLS_NOT_VALID: begin
            res_push = 1'b1;
            res.kind = K_NOT_VALID;
          end
          default: begin
            res_push = 1'b1;
            res.kind = K_STRAY;
          end
        endcase
      end else begin
        unique case (cmd.cls)
          CLS_END: begin
            in_block_nxt    = 1'b0;
            seen_nxt        = '0;
            res_push        = 1'b1;
            res.kind        = K_END;
            res.event_count = cmd.event_count;
          end
          CLS_CHAN_BAD: begin
            in_block_nxt = 1'b0;
            seen_nxt     = '0;
            res_push     = 1'b1;
            res.kind     = K_CHAN_ERR;
            res.channel  = cmd.channel;
          end
          CLS_DATA: begin
            res_push    = 1'b1;
            res.kind    = K_DATA;
            res.channel = cmd.channel;
            res.value   = cmd.value;
            res.stored  = cmd.stored;
            seen_nxt    = seen_inc;
            // One data word past the announced count still reports, then closes.
            if (seen_inc > {1'b0, expected_r}) begin
              res.closed_by_count = 1'b1;
              in_block_nxt        = 1'b0;
              seen_nxt            = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_block_r <= 1'b0;
      expected_r <= '0;
      seen_r     <= '0;
    end else begin
      in_block_r <= in_block_nxt;
      expected_r <= expected_nxt;
      seen_r     <= seen_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/adc_event_block_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                      Request taken when
// input     in_push, in_full, in_word                  in_push && !in_full
// result    out_pop, out_empty, out_kind .. out_event  out_pop && !out_empty
// config    cfg_we, cfg_index, cfg_data                cfg_we
//
// One word is accepted per cycle, sustained while the output queue has room. A
// result reaches the output ports once its word has passed the classification
// queue and the decode logic has written the result into the output queue.
// Both queues hold two entries.
// Reset is synchronous: it empties both queues, closes any open block and
// returns the registers to their reset values. in_full rises only when the
// output queue has backed up into the classification queue.
module adc_event_block_decoder import adc_ebd_pkg::*; #(
  parameter int Channels = ChannelsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire logic [WordW-1:0]    in_word,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic [2:0]               out_kind,
  output logic [ChanW-1:0]         out_channel,
  output logic [ValueW-1:0]        out_value,
  output logic                     out_stored,
  output logic                     out_closed_by_count,
  output logic [EventW-1:0]        out_event_count,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cmd_t            front_cmd, back_cmd;
  logic [CmdW-1:0] back_cmd_bits;
  logic            cmd_empty, cmd_pop;
  result_t         back_res, out_res;
  logic [ResultW-1:0] out_res_bits;
  logic            res_push, res_full;

  adc_ebd_front #(.Channels(Channels)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .word      (in_word),
    .cmd       (front_cmd)
  );

  adc_ebd_fifo #(.Width(CmdW), .Depth(QueueDepth)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (back_cmd_bits),
    .empty (cmd_empty)
  );

  assign back_cmd = cmd_t'(back_cmd_bits);

  adc_ebd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  adc_ebd_fifo #(.Width(ResultW), .Depth(QueueDepth)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_res_bits),
    .empty (out_empty)
  );

  assign out_res             = result_t'(out_res_bits);
  assign out_kind            = out_res.kind;
  assign out_channel         = out_res.channel;
  assign out_value           = out_res.value;
  assign out_stored          = out_res.stored;
  assign out_closed_by_count = out_res.closed_by_count;
  assign out_event_count     = out_res.event_count;

endmodule
`default_nettype wire

### tb/tb_adc_event_block_decoder.sv
`timescale 1ns / 1ps
module tb_adc_event_block_decoder;
  import adc_ebd_pkg::*;

  localparam int QuietLimit  = 5000;
  localparam int DrainCycles = 8;
  localparam int PhaseWords  = 255;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  logic [WordW-1:0]    in_word;
  logic                out_empty;
  logic                out_pop;
  logic [2:0]          out_kind;
  logic [ChanW-1:0]    out_channel;
  logic [ValueW-1:0]   out_value;
  logic                out_stored;
  logic                out_closed_by_count;
  logic [EventW-1:0]   out_event_count;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // Register copies and block state used to work out the expected results.
  logic [SlotW-1:0]  slot_reg;
  logic [CrateW-1:0] crate_reg;
  logic [MaxW-1:0]   max_reg;
  logic              blk_open;
  logic [CountW-1:0] blk_words;
  logic [SeenW-1:0]  blk_seen;

  logic [WordW-1:0] word_backlog[$];
  result_t          result_due[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int errors;
  int words_taken;
  int results_checked;
  int quiet;
  int kind_hits[6];
  int stored_hits;
  int count_closes;

  adc_event_block_decoder #(
    .Channels(ChannelsDefault)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_word            (in_word),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_channel        (out_channel),
    .out_value          (out_value),
    .out_stored         (out_stored),
    .out_closed_by_count(out_closed_by_count),
    .out_event_count    (out_event_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void decode_word(input logic [WordW-1:0] w);
    logic [2:0]       wtype;
    logic [ChanW-1:0] ch;
    result_t          r;
    wtype = w[26:24];
    ch    = w[20:17];
    r     = '0;
    if (!blk_open) begin
      if (wtype == TYPE_NOT_VALID) begin
        r.kind = K_NOT_VALID;
        result_due.push_back(r);
      end else if (wtype == TYPE_HEADER) begin
        if (w[31:27] != slot_reg || w[23:16] != crate_reg) begin
          r.kind = K_MISMATCH;
          result_due.push_back(r);
        end else begin
          blk_open  = 1'b1;
          blk_words = w[13:8];
          blk_seen  = '0;
        end
      end else begin
        r.kind = K_STRAY;
        result_due.push_back(r);
      end
    end else if (wtype == TYPE_END) begin
      blk_open      = 1'b0;
      blk_seen      = '0;
      r.kind        = K_END;
      r.event_count = w[23:0];
      result_due.push_back(r);
    end else if (wtype == TYPE_DATA) begin
      if (int'(ch) >= ChannelsDefault) begin
        blk_open  = 1'b0;
        blk_seen  = '0;
        r.kind    = K_CHAN_ERR;
        r.channel = ch;
      end else begin
        r.kind    = K_DATA;
        r.channel = ch;
        r.value   = w[11:0];
        // Under-threshold and overflow flags both veto storage.
        r.stored  = (w[13:12] == 2'b00) && ({1'b0, w[11:0]} <= max_reg);
        blk_seen  = blk_seen + 1'b1;
        if (blk_seen > {1'b0, blk_words}) begin
          r.closed_by_count = 1'b1;
          blk_open          = 1'b0;
          blk_seen          = '0;
        end
      end
      result_due.push_back(r);
    end
  endfunction

  function automatic logic [WordW-1:0] typed_word(input logic [2:0] wtype);
    logic [WordW-1:0] w;
    w        = $urandom;
    w[26:24] = wtype;
    return w;
  endfunction

  function automatic logic [WordW-1:0] hdr_word(input logic [SlotW-1:0] slot,
                                                input logic [CrateW-1:0] crate,
                                                input logic [CountW-1:0] count);
    logic [WordW-1:0] w;
    w        = typed_word(TYPE_HEADER);
    w[31:27] = slot;
    w[23:16] = crate;
    w[13:8]  = count;
    return w;
  endfunction

  function automatic logic [WordW-1:0] data_word(input logic [ChanW-1:0] ch, input logic ut,
                                                 input logic ov, input logic [ValueW-1:0] val);
    logic [WordW-1:0] w;
    w        = typed_word(TYPE_DATA);
    w[20:17] = ch;
    w[13]    = ut;
    w[12]    = ov;
    w[11:0]  = val;
    return w;
  endfunction

  function automatic logic [WordW-1:0] end_word(input logic [EventW-1:0] count);
    logic [WordW-1:0] w;
    w        = typed_word(TYPE_END);
    w[23:0]  = count;
    return w;
  endfunction

  // The odd type codes have no meaning in the buffer format.
  function automatic logic [WordW-1:0] unused_word();
    return typed_word(3'(2 * $urandom_range(0, 3) + 1));
  endfunction

  function automatic logic [WordW-1:0] rand_data_word();
    int v;
    case ($urandom_range(0, 5))
      0:       v = int'(max_reg);
      1:       v = int'(max_reg) + 1;
      2:       v = int'(max_reg) - 1;
      3:       v = 0;
      4:       v = 4095;
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return data_word(4'($urandom), $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 15,
                     12'(v));
  endfunction

  function automatic logic [WordW-1:0] mismatch_hdr_word();
    logic [SlotW-1:0]  slot;
    logic [CrateW-1:0] crate;
    slot  = slot_reg;
    crate = crate_reg;
    if ($urandom_range(0, 1)) slot = slot ^ 5'($urandom_range(1, 31));
    if ($urandom_range(0, 1) || slot == slot_reg) crate = crate ^ 8'($urandom_range(1, 255));
    return hdr_word(slot, crate, 6'($urandom));
  endfunction

  // One well-formed block with random content, or a broken one, or a word of noise.
  task automatic plan_sequence(inout int counted);
    int               n;
    int               dwords;
    int               pick;
    logic [EventW-1:0] evt;
    if ($urandom_range(0, 99) < 70) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
      word_backlog.push_back(hdr_word(slot_reg, crate_reg, 6'(n)));
      counted++;
      pick = $urandom_range(0, 99);
      if (pick < 15) dwords = n + 1;
      else if (pick < 25) dwords = $urandom_range(0, n);
      else dwords = n;
      for (int i = 0; i < dwords; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0:       word_backlog.push_back(typed_word(TYPE_NOT_VALID));
            1:       word_backlog.push_back(typed_word(TYPE_HEADER));
            default: word_backlog.push_back(unused_word());
          endcase
          counted++;
        end
        word_backlog.push_back(rand_data_word());
        counted++;
      end
      if (dwords <= n) begin
        case ($urandom_range(0, 3))
          0:       evt = '0;
          1:       evt = '1;
          default: evt = 24'($urandom);
        endcase
        word_backlog.push_back(end_word(evt));
        counted++;
      end
    end else begin
      case ($urandom_range(0, 5))
        0:       word_backlog.push_back(typed_word(TYPE_NOT_VALID));
        1:       word_backlog.push_back(mismatch_hdr_word());
        2:       word_backlog.push_back(typed_word(TYPE_DATA));
        3:       word_backlog.push_back(typed_word(TYPE_END));
        4:       word_backlog.push_back(unused_word());
        default: word_backlog.push_back($urandom);
      endcase
      counted++;
    end
  endtask

  task automatic fill_phase(input int target);
    int counted;
    counted = 0;
    while (counted < target) plan_sequence(counted);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_SLOT:  slot_reg  = d[SlotW-1:0];
      REG_CRATE: crate_reg = d[CrateW-1:0];
      REG_MAX:   max_reg   = d;
      default:   ;
    endcase
  endtask

  task automatic apply_setting(input int setting);
    logic [SlotW-1:0]  slot;
    logic [CrateW-1:0] crate;
    logic [MaxW-1:0]   maxv;
    logic [CfgDataW-1:0] d;
    slot  = 5'($urandom);
    crate = 8'($urandom);
    case (setting)
      1: begin
        slot  = '1;
        crate = '1;
        maxv  = '0;
      end
      2: maxv = 13'($urandom_range(1, 4095));
      3: begin
        slot  = '0;
        crate = '0;
        maxv  = 13'd4095;
      end
      4: maxv = MAX_VALUE_RESET;
      default: maxv = 13'($urandom_range(0, 4096));
    endcase
    // Bits above a narrow register are filled at random; they must be dropped.
    d = 13'($urandom);
    d[SlotW-1:0] = slot;
    write_reg(REG_SLOT, d);
    d = 13'($urandom);
    d[CrateW-1:0] = crate;
    write_reg(REG_CRATE, d);
    write_reg(REG_MAX, maxv);
  endtask

  // A header causes no result, so allow for one still in the pipeline.
  task automatic wait_drained();
    while (word_backlog.size() != 0 || in_push || result_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Input request driver; a word is held until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        decode_word(in_word);
        words_taken++;
      end
      if (in_push && in_full) begin
        in_push <= 1'b1;
      end else if (word_backlog.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_push <= 1'b1;
        in_word <= word_backlog.pop_front();
      end else begin
        in_push <= 1'b0;
        in_word <= $urandom;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (result_due.size() == 0) begin
          $display("%0t: unexpected result, kind %0d channel %0d value %0d", $time, out_kind,
                   out_channel, out_value);
          errors++;
        end else begin
          want = result_due.pop_front();
          compare_field("kind", 32'(want.kind), 32'(out_kind));
          compare_field("channel", 32'(want.channel), 32'(out_channel));
          compare_field("value", 32'(want.value), 32'(out_value));
          compare_field("stored", 32'(want.stored), 32'(out_stored));
          compare_field("closed_by_count", 32'(want.closed_by_count),
                        32'(out_closed_by_count));
          compare_field("event_count", 32'(want.event_count), 32'(out_event_count));
          results_checked++;
          kind_hits[int'(want.kind)]++;
          if (want.stored) stored_hits++;
          if (want.closed_by_count) count_closes++;
        end
      end
      out_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("%0t: no request accepted for %0d cycles", $time, quiet);
        $display("tb_adc_event_block_decoder: FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_word   <= '0;
    out_pop   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SLOT;
    cfg_data  <= '0;
    slot_reg  = '0;
    crate_reg = '0;
    max_reg   = MAX_VALUE_RESET;
    blk_open  = 1'b0;
    blk_words = '0;
    blk_seen  = '0;
    tx_idle_pct = 17;
    rx_idle_pct = 47;
    errors = 0;
    words_taken = 0;
    results_checked = 0;
    quiet = 0;
    stored_hits = 0;
    count_closes = 0;
    foreach (kind_hits[i]) kind_hits[i] = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset register values.
    word_backlog.push_back(typed_word(TYPE_NOT_VALID));
    word_backlog.push_back(32'h0000_0000);
    word_backlog.push_back(32'hFFFF_FFFF);
    word_backlog.push_back(end_word(24'($urandom)));
    word_backlog.push_back(typed_word(TYPE_DATA + 3'd1));
    word_backlog.push_back(typed_word(TYPE_HEADER + 3'd1));
    word_backlog.push_back(typed_word(TYPE_END + 3'd1));
    word_backlog.push_back(hdr_word(5'd1, 8'd0, 6'd2));
    word_backlog.push_back(hdr_word(5'd0, 8'd1, 6'd2));
    word_backlog.push_back(hdr_word(5'd0, 8'd0, 6'd2));
    word_backlog.push_back(data_word(4'd0, 1'b0, 1'b0, 12'd0));
    word_backlog.push_back(data_word(4'd15, 1'b1, 1'b0, 12'hFFF));
    word_backlog.push_back(typed_word(TYPE_NOT_VALID));
    word_backlog.push_back(hdr_word(5'd0, 8'd0, 6'd5));
    word_backlog.push_back(typed_word(TYPE_NOT_VALID + 3'd1));
    word_backlog.push_back(data_word(4'd7, 1'b0, 1'b1, 12'd100));
    word_backlog.push_back(data_word(4'd3, 1'b0, 1'b0, 12'hFFF));
    word_backlog.push_back(hdr_word(5'd0, 8'd0, 6'd0));
    word_backlog.push_back(end_word(24'hFF_FFFF));
    word_backlog.push_back(hdr_word(5'd0, 8'd0, 6'd63));
    word_backlog.push_back(data_word(4'd0, 1'b1, 1'b1, 12'hFFF));
    word_backlog.push_back(end_word(24'h00_0000));
    word_backlog.push_back(hdr_word(5'd0, 8'd0, 6'd0));
    word_backlog.push_back(data_word(4'd1, 1'b0, 1'b0, 12'd1));

    fill_phase(PhaseWords);
    for (int setting = 1; setting <= 5; setting++) begin
      wait_drained();
      if (setting == 2) begin
        tx_idle_pct = 47;
        rx_idle_pct = 17;
      end else if (setting == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      apply_setting(setting);
      fill_phase(PhaseWords);
    end
    wait_drained();

    $display("Checked %0d results from %0d words, six register settings, three stall mixes.",
             results_checked, words_taken);
    $write("Seen: %0d data (%0d stored, %0d count closures), %0d ends, ",
           kind_hits[K_DATA], stored_hits, count_closes, kind_hits[K_END]);
    $display("%0d not valid, %0d header mismatches, %0d channel errors, %0d stray.",
             kind_hits[K_NOT_VALID], kind_hits[K_MISMATCH], kind_hits[K_CHAN_ERR],
             kind_hits[K_STRAY]);
    if (errors == 0) begin
      $display("tb_adc_event_block_decoder: PASS");
    end else begin
      $display("tb_adc_event_block_decoder: FAIL");
    end
    $finish;
  end

endmodule
